@@ design/afsp_pkg.sv @@
// package: shared types, constants and crc-8 fold for the adc sample frame packer
`timescale 1ns / 1ps

package afsp_pkg;

    localparam logic [7:0] CRC_POLY          = 8'h8D;
    localparam logic [3:0] SAMPLES_PER_FRAME = 4'd10;
    localparam logic [3:0] LAST_SLOT         = SAMPLES_PER_FRAME - 4'd1;
    localparam logic [7:0] HEADER_RESET      = 8'd10;
    localparam logic [8:0] BLOCK_RESET       = 9'd100;

    localparam logic [1:0] REG_HEADER_BYTE  = 2'd0;
    localparam logic [1:0] REG_BLOCK_FRAMES = 2'd1;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_slot;

    typedef struct packed {
        logic             valid;
        logic [2:0][7:0]  bytes;
        logic [1:0]       cnt;
        logic             crc_last;
    } t_load;

    function automatic t_byte crc_fold(input t_byte crc, input t_byte data);
        t_byte c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/afsp_emit.sv @@
// module: pending word queue, output register and running crc-8
`timescale 1ns / 1ps

module afsp_emit
    import afsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_load i_load,
    output logic  o_ready,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_byte o_out_byte,
    output logic  o_frame_end,
    output logic  o_run_end
);

    logic [2:0][7:0] r_pb, n_pb;
    logic [1:0]      r_cnt, n_cnt;
    logic            r_pcrc, n_pcrc;
    t_byte           r_crc, n_crc;
    logic            r_ov, n_ov;
    t_byte           r_obyte, n_obyte;
    logic            r_ofe, n_ofe;
    logic            r_ore, n_ore;

    logic  move;
    logic  last;
    logic  mv_crc;
    t_byte mv_byte;

    always_comb begin
        move    = (r_cnt != 2'd0) && (!r_ov || !i_out_stall);
        last    = (r_cnt == 2'd1);
        mv_crc  = last && r_pcrc;
        mv_byte = mv_crc ? r_crc : r_pb[0];
        o_ready = (r_cnt == 2'd0) || (last && move);

        n_pb    = r_pb;
        n_cnt   = r_cnt;
        n_pcrc  = r_pcrc;
        n_crc   = r_crc;
        n_obyte = r_obyte;
        n_ofe   = r_ofe;
        n_ore   = r_ore;
        n_ov    = move || (r_ov && i_out_stall);

        if (move) begin
            n_pb[0] = r_pb[1];
            n_pb[1] = r_pb[2];
            n_cnt   = r_cnt - 2'd1;
            n_obyte = mv_byte;
            n_ofe   = mv_crc;
            n_ore   = last;
            n_crc   = mv_crc ? 8'h00 : crc_fold(r_crc, mv_byte);
        end

        if (i_load.valid) begin
            n_pb   = i_load.bytes;
            n_cnt  = i_load.cnt;
            n_pcrc = i_load.crc_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_pcrc <= 1'b0;
            r_crc  <= 8'h00;
            r_ov   <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_pcrc <= n_pcrc;
            r_crc  <= n_crc;
            r_ov   <= n_ov;
        end
        r_pb    <= n_pb;
        r_obyte <= n_obyte;
        r_ofe   <= n_ofe;
        r_ore   <= n_ore;
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_obyte;
    assign o_frame_end = r_ofe;
    assign o_run_end   = r_ore;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> (r_ov && $stable(r_obyte)))
        else $error("stalled output word changed");

    a_fend_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ofe) |-> r_ore)
        else $error("crc word not last of its sample");

    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.valid |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && move)))
        else $error("load overwrote pending words");

    a_crc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && mv_crc) |=> r_crc == 8'h00)
        else $error("crc not cleared after frame");

endmodule

@@ design/adc_sample_frame_packer_crc8.sv @@
// top level: 12-bit adc sample framer with crc-8 closing word
//
// input channel: i_in_valid / o_in_stall carry one 12-bit sample on i_sample.
// output channel: o_out_valid / i_out_stall carry one frame word on o_out_byte,
// with o_frame_end on the crc word and o_run_end on the last word of a sample.
// ten samples make an 18-word frame: header, sequence number, fifteen packed
// sample words (high bits first) and a crc-8 (poly 0x8d, init 0) of the rest.
// a sample yields one, two or three words; the output register sends one word
// a cycle while the receiver does not stall, and a new sample is taken in the
// cycle its last word moves to the output register. an accepted sample's
// words enter the pending queue, and from there move to the output register.
// configuration: i_cfg_we with i_cfg_index 0 (header) or 1 (block frames);
// other indexes are ignored. write only while idle.
// reset clears slot, sequence, crc and queue; header returns to 10, block
// frames to 100. while the receiver stalls, the output word holds and input
// is stalled once the pending words of the current sample cannot drain.
`timescale 1ns / 1ps

module adc_sample_frame_packer_crc8
    import afsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [11:0] i_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    output logic        o_run_end
);

    t_byte      r_header, n_header;
    logic [8:0] r_blocks, n_blocks;
    t_slot      r_slot, n_slot;
    logic [3:0] r_held, n_held;
    t_byte      r_seq, n_seq;

    t_load      load;
    logic       ready;
    logic       acc;
    logic [8:0] seq_inc;

    always_comb begin
        acc     = i_in_valid && ready;
        seq_inc = {1'b0, r_seq} + 9'd1;

        n_header = r_header;
        n_blocks = r_blocks;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEADER_BYTE:  n_header = i_cfg_data[7:0];
                REG_BLOCK_FRAMES: n_blocks = i_cfg_data;
                default: ;
            endcase
        end

        n_slot = r_slot;
        n_held = r_held;
        n_seq  = r_seq;

        load.valid    = acc;
        load.bytes    = '0;
        load.cnt      = 2'd1;
        load.crc_last = 1'b0;

        if (r_slot == 4'd0) begin
            load.bytes[0] = r_header;
            load.bytes[1] = r_seq;
            load.bytes[2] = i_sample[11:4];
            load.cnt      = 2'd3;
            n_held        = i_sample[3:0];
            n_slot        = r_slot + 4'd1;
        end else if (r_slot < LAST_SLOT && !r_slot[0]) begin
            load.bytes[0] = i_sample[11:4];
            load.cnt      = 2'd1;
            n_held        = i_sample[3:0];
            n_slot        = r_slot + 4'd1;
        end else begin
            load.bytes[0] = {r_held, i_sample[11:8]};
            load.bytes[1] = i_sample[7:0];
            if (r_slot >= LAST_SLOT) begin
                load.cnt      = 2'd3;
                load.crc_last = 1'b1;
                n_slot        = 4'd0;
                n_seq         = (seq_inc >= r_blocks) ? 8'h00 : seq_inc[7:0];
            end else begin
                load.cnt = 2'd2;
                n_slot   = r_slot + 4'd1;
            end
        end

        if (!acc) begin
            n_slot = r_slot;
            n_held = r_held;
            n_seq  = r_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_blocks <= BLOCK_RESET;
            r_slot   <= 4'd0;
            r_held   <= 4'd0;
            r_seq    <= 8'h00;
        end else begin
            r_header <= n_header;
            r_blocks <= n_blocks;
            r_slot   <= n_slot;
            r_held   <= n_held;
            r_seq    <= n_seq;
        end
    end

    afsp_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_run_end   (o_run_end)
    );

    assign o_in_stall = !ready;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("slot out of range");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_slot == LAST_SLOT) |=> r_slot == 4'd0)
        else $error("slot did not wrap after closing sample");

    a_seq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_slot != LAST_SLOT) |=> $stable(r_seq))
        else $error("sequence moved inside a frame");

endmodule

@@ sim/afsp_frame_checker.sv @@
// checker: predicts frame words from accepted samples and writes, compares the output
`timescale 1ns / 1ps

module afsp_frame_checker
    import afsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [11:0] i_sample,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_frame_end,
    input  logic        i_run_end,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       run_end;
    } t_frame_word;

    t_frame_word words_due [$];

    t_byte      hdr_reg;
    logic [8:0] wrap_reg;
    t_slot      pos;
    logic [3:0] nibble;
    t_byte      crc_acc;
    t_byte      seq_no;
    int         errs = 0;

    // msb-first, one data bit per step
    function automatic t_byte crc8_update(input t_byte crc, input t_byte data);
        t_byte r;
        logic  fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    task automatic stage_word(input t_byte data, input logic fend);
        crc_acc = crc8_update(crc_acc, data);
        words_due.push_back('{data, fend, 1'b0});
    endtask

    task automatic predict_sample(input logic [11:0] s);
        t_frame_word last;
        logic [8:0]  next_seq;
        if (pos == 4'd0) begin
            crc_acc = 8'h00;
            stage_word(hdr_reg, 1'b0);
            stage_word(seq_no, 1'b0);
        end
        if (pos < LAST_SLOT && !pos[0]) begin
            stage_word(s[11:4], 1'b0);
            nibble = s[3:0];
            pos    = pos + 4'd1;
        end else begin
            stage_word({nibble, s[11:8]}, 1'b0);
            stage_word(s[7:0], 1'b0);
            if (pos >= LAST_SLOT) begin
                stage_word(crc_acc, 1'b1);
                crc_acc  = 8'h00;
                next_seq = {1'b0, seq_no} + 9'd1;
                seq_no   = (next_seq >= wrap_reg) ? 8'h00 : next_seq[7:0];
                pos      = 4'd0;
            end else begin
                pos = pos + 4'd1;
            end
        end
        last = words_due.pop_back();
        last.run_end = 1'b1;
        words_due.push_back(last);
    endtask

    always @(posedge i_clk) begin
        t_frame_word got;
        t_frame_word want;
        if (!i_rst_n) begin
            words_due.delete();
            hdr_reg  = HEADER_RESET;
            wrap_reg = BLOCK_RESET;
            pos      = 4'd0;
            nibble   = 4'd0;
            crc_acc  = 8'h00;
            seq_no   = 8'h00;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_out_byte, i_frame_end, i_run_end};
                if (words_due.size() == 0) begin
                    $display("%0t: word %02h fe %b re %b arrived with nothing expected",
                             $time, got.data, got.frame_end, got.run_end);
                    errs++;
                end else begin
                    want = words_due.pop_front();
                    if (got.data !== want.data)
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.data, got.data);
                    if (got.frame_end !== want.frame_end)
                        $display("%0t: frame_end expected %b got %b",
                                 $time, want.frame_end, got.frame_end);
                    if (got.run_end !== want.run_end)
                        $display("%0t: run_end expected %b got %b",
                                 $time, want.run_end, got.run_end);
                    if (got !== want)
                        errs++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HEADER_BYTE:  hdr_reg  = i_cfg_data[7:0];
                    REG_BLOCK_FRAMES: wrap_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_sample(i_sample);
        end
        o_errors  <= errs;
        o_pending <= words_due.size();
    end

endmodule

@@ sim/tb_adc_sample_frame_packer_crc8.sv @@
// testbench top: clock, reset, sample and register stimulus, verdict
`timescale 1ns / 1ps

module tb_adc_sample_frame_packer_crc8;
    import afsp_pkg::*;

    localparam int         CYCLE_LIMIT  = 100000;
    localparam int         LONG_HOLD    = 150;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         PHASES       = 8;
    localparam int         PHASE_WORDS  = 45;
    localparam logic [1:0] REG_SPARE_2  = 2'd2;
    localparam logic [1:0] REG_SPARE_3  = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_HEADER_BYTE;
    logic [8:0]  cfg_data  = 9'd0;
    logic        in_valid  = 1'b0;
    logic [11:0] sample    = 12'd0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic        run_end;

    int errors;
    int pending;
    int cycle_count = 0;
    bit no_gaps     = 1'b0;
    bit hold_out    = 1'b0;

    logic [11:0] corner [10];
    logic [8:0]  wrap_choice [PHASES];

    adc_sample_frame_packer_crc8 i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample    (sample),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_byte  (out_byte),
        .o_frame_end (frame_end),
        .o_run_end   (run_end)
    );

    afsp_frame_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_sample    (sample),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_byte  (out_byte),
        .i_frame_end (frame_end),
        .i_run_end   (run_end),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_adc_sample_frame_packer_crc8: done, errors");
            $finish;
        end
    end

    task automatic send_sample(input logic [11:0] s);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // output side: random stall before each word, one long hold on request
    initial begin
        int gap;
        wait (rst_n);
        forever begin
            if (hold_out) begin
                hold_out = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        logic [11:0] s;
        logic [8:0]  hdr;
        corner = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h800,
                   12'h7FF, 12'h00F, 12'hF00, 12'h0F0, 12'h001};
        wrap_choice = '{9'd2, 9'd0, 9'd256, 9'd3, 9'd511, 9'd1, 9'd5, 9'd4};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one frame on register defaults
        for (int k = 0; k < 10; k++)
            send_sample(corner[k]);
        wait_drained();

        // sequence held at zero, unused indexes must not disturb anything
        write_reg(REG_HEADER_BYTE, 9'h0FF);
        write_reg(REG_BLOCK_FRAMES, 9'd1);
        write_reg(REG_SPARE_2, 9'h1FF);
        write_reg(REG_SPARE_3, 9'h000);
        for (int k = 0; k < 12; k++)
            send_sample(k[0] ? 12'hFFF : 12'h000);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0:       hdr = 9'h000;
                1:       hdr = 9'h1FF;
                default: hdr = 9'($urandom_range(0, 511));
            endcase
            write_reg(REG_HEADER_BYTE, hdr);
            write_reg(REG_BLOCK_FRAMES,
                      (p == PHASES - 1) ? 9'($urandom_range(1, 256)) : wrap_choice[p]);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (p == 1)
                hold_out = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                case ($urandom_range(0, 7))
                    0:       s = 12'h000;
                    1:       s = 12'hFFF;
                    default: s = 12'($urandom_range(0, 4095));
                endcase
                send_sample(s);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("tb_adc_sample_frame_packer_crc8: done, clean");
        end else begin
            $display("tb_adc_sample_frame_packer_crc8: done, errors");
        end
        $finish;
    end

endmodule

@@ adc_sample_frame_packer_crc8.f @@
design/afsp_pkg.sv
design/afsp_emit.sv
design/adc_sample_frame_packer_crc8.sv
sim/afsp_frame_checker.sv
sim/tb_adc_sample_frame_packer_crc8.sv
